@@ src/csma_pkg.sv @@
// csma_pkg: shared types, codes and helpers of the csma mac controller
// no dependencies; imported by csma_fifo_mem, csma_ctrl and csma_mac_tx_rx_controller_top
`default_nettype none

package csma_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ENTRY_W   = 17;
	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
	localparam logic [7:0]  MAX_PAYLOAD    = 8'd120;
	localparam logic [15:0] BACKOFF_BASE   = 16'd16;
	localparam logic [4:0]  BACKOFF_SHIFT  = 5'd5;
	localparam logic [1:0]  TYPE_DATA      = 2'h1;
	localparam logic [1:0]  TYPE_ACK       = 2'h2;
	localparam int          ACK_REQ_BIT    = 7;

	localparam logic [15:0] NODE_ADDR_RST  = 16'd0;
	localparam logic [15:0] ACK_WAIT_RST   = 16'd500;
	localparam logic [3:0]  RETRY_LIM_RST  = 4'd3;

	typedef enum logic [1:0] {
		CMD_QUEUE = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CCA   = 2'd2,
		CMD_RX    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_NODE_ADDR = 2'd0,
		REG_ACK_WAIT  = 2'd1,
		REG_RETRY_LIM = 2'd2
	} reg_idx_t;

	localparam logic [1:0] OUTCOME_NONE    = 2'd0;
	localparam logic [1:0] OUTCOME_SENT    = 2'd1;
	localparam logic [1:0] OUTCOME_GIVENUP = 2'd2;

	localparam logic [1:0] QSTAT_NONE   = 2'd0;
	localparam logic [1:0] QSTAT_ACCEPT = 2'd1;
	localparam logic [1:0] QSTAT_REJECT = 2'd2;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_BACKOFF = 4'b0010,
		MODE_CCA     = 4'b0100,
		MODE_ACK     = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0]  rx_ctrl;
		logic [15:0] rx_src;
		logic [15:0] rx_dst;
		logic        channel_clear;
		logic [15:0] random_value;
		logic [7:0]  payload_length;
		logic        ack_request;
		logic [15:0] dest_address;
	} item_t;

	typedef struct packed {
		logic [15:0] deliver_src;
		logic        deliver;
		logic [15:0] ack_dest;
		logic        send_ack;
		logic [1:0]  queue_status;
		logic [1:0]  tx_outcome;
		logic [15:0] tx_dest;
		logic        start_tx;
	} result_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_wr_t;

	// (rnd and (2^(att+5))-1) + 16, saturated to 16 bits
	function automatic logic [15:0] backoff_len(input logic [3:0] att, input logic [15:0] rnd);
		logic [4:0]  sh;
		logic [15:0] mask;
		logic [16:0] w;
		sh = {1'b0, att} + BACKOFF_SHIFT;
		for (int i = 0; i < 16; i++) begin
			mask[i] = (5'(i) < sh);
		end
		w = {1'b0, rnd & mask} + {1'b0, BACKOFF_BASE};
		return w[16] ? 16'hFFFF : w[15:0];
	endfunction

endpackage

`default_nettype wire

@@ src/csma_fifo_mem.sv @@
// csma_fifo_mem: frame queue storage, one write and one registered read port
// depends on csma_pkg; a write to the address being read is forwarded
`default_nettype none

module csma_fifo_mem #(
	parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_DEF,
	parameter int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [PTR_W-1:0]             wr_addr,
	input  wire logic [csma_pkg::ENTRY_W-1:0] wr_data,
	input  wire logic [PTR_W-1:0]             rd_addr,
	output logic      [csma_pkg::ENTRY_W-1:0] rd_data
);
	import csma_pkg::*;

	logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ src/csma_ctrl.sv @@
// csma_ctrl: mac state, queue pointers and configuration registers
// depends on csma_pkg and csma_fifo_mem; one accepted item updated per cycle
`default_nettype none

module csma_ctrl #(
	parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire csma_pkg::cfg_wr_t cfg_wr,
	input  wire logic              item_valid,
	input  wire csma_pkg::cmd_t    item_cmd,
	input  wire csma_pkg::item_t   item,
	output logic                   res_valid,
	output csma_pkg::result_t      res
);
	import csma_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [15:0]        node_addr_q;
	logic [15:0]        ack_wait_q;
	logic [3:0]         retry_lim_q;

	mode_t              mode_q, mode_n;
	logic [3:0]         attempt_q, attempt_n;
	logic [15:0]        countdown_q, countdown_n;
	logic [15:0]        cur_dest_q, cur_dest_n;
	logic               cur_ack_q, cur_ack_n;
	logic [PTR_W-1:0]   rp_q, rp_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;

	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] head;
	logic [SUM_W-1:0]   slot_sum;
	logic [SUM_W-1:0]   rp_inc;
	logic [3:0]         retry_lim_eff;
	logic [3:0]         attempt_inc;
	logic               give_up;
	logic [1:0]         rx_type;
	result_t            res_n;

	csma_fifo_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PTR_W      (PTR_W)
	) u_fifo (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rp_n),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q <= NODE_ADDR_RST;
			ack_wait_q  <= ACK_WAIT_RST;
			retry_lim_q <= RETRY_LIM_RST;
		end else if (cfg_wr.valid) begin
			case (reg_idx_t'(cfg_wr.index))
				REG_NODE_ADDR: node_addr_q <= cfg_wr.data;
				REG_ACK_WAIT:  ack_wait_q  <= cfg_wr.data;
				REG_RETRY_LIM: retry_lim_q <= cfg_wr.data[3:0];
				default:       ;
			endcase
		end
	end

	// queue write slot and pointer increment with wrap at the depth
	always_comb begin
		slot_sum = SUM_W'(rp_q) + SUM_W'(cnt_q);
		if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
		end
		rp_inc = SUM_W'(rp_q) + SUM_W'(1);
		if (rp_inc >= SUM_W'(QUEUE_DEPTH)) begin
			rp_inc = '0;
		end
	end

	assign wr_addr       = slot_sum[PTR_W-1:0];
	assign wr_data       = {item.dest_address, item.ack_request};
	assign wr_en         = item_valid && (item_cmd == CMD_QUEUE)
	                       && (item.payload_length <= MAX_PAYLOAD)
	                       && (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign head          = (wr_en && (cnt_q == '0)) ? wr_data : rd_data;
	assign retry_lim_eff = (retry_lim_q == 4'd0) ? 4'd1 : retry_lim_q;
	assign attempt_inc   = attempt_q + 4'd1;
	assign give_up       = (attempt_inc >= retry_lim_eff) || (attempt_inc == 4'd0);
	assign rx_type       = item.rx_ctrl[1:0];

	always_comb begin
		mode_n      = mode_q;
		attempt_n   = attempt_q;
		countdown_n = countdown_q;
		cur_dest_n  = cur_dest_q;
		cur_ack_n   = cur_ack_q;
		rp_n        = rp_q;
		cnt_n       = cnt_q;
		res_n       = '0;

		if (item_valid) begin
			case (item_cmd)
				CMD_QUEUE: begin
					if (wr_en) begin
						cnt_n              = cnt_q + CNT_W'(1);
						res_n.queue_status = QSTAT_ACCEPT;
					end else begin
						res_n.queue_status = QSTAT_REJECT;
					end
				end
				CMD_TICK: begin
					if (mode_q == MODE_BACKOFF || mode_q == MODE_ACK) begin
						if (countdown_q <= 16'd1) begin
							countdown_n = '0;
							if (mode_q == MODE_BACKOFF) begin
								res_n.start_tx = 1'b1;
								res_n.tx_dest  = cur_dest_q;
								mode_n         = MODE_CCA;
							end else begin
								attempt_n = attempt_inc;
								if (give_up) begin
									mode_n           = MODE_IDLE;
									res_n.tx_outcome = OUTCOME_GIVENUP;
								end else begin
									countdown_n = backoff_len(attempt_inc, item.random_value);
									mode_n      = MODE_BACKOFF;
								end
							end
						end else begin
							countdown_n = countdown_q - 16'd1;
						end
					end
				end
				CMD_CCA: begin
					if (mode_q == MODE_CCA) begin
						if (item.channel_clear) begin
							if (cur_ack_q) begin
								countdown_n = ack_wait_q;
								mode_n      = MODE_ACK;
							end else begin
								res_n.tx_outcome = OUTCOME_SENT;
								mode_n           = MODE_IDLE;
							end
						end else begin
							attempt_n = attempt_inc;
							if (give_up) begin
								mode_n           = MODE_IDLE;
								res_n.tx_outcome = OUTCOME_GIVENUP;
							end else begin
								countdown_n = backoff_len(attempt_inc, item.random_value);
								mode_n      = MODE_BACKOFF;
							end
						end
					end
				end
				CMD_RX: begin
					if (item.rx_dst == node_addr_q) begin
						if (rx_type == TYPE_ACK) begin
							if (mode_q == MODE_ACK && item.rx_src == cur_dest_q) begin
								res_n.tx_outcome = OUTCOME_SENT;
								mode_n           = MODE_IDLE;
							end
						end else begin
							if (rx_type == TYPE_DATA && item.rx_ctrl[ACK_REQ_BIT]) begin
								res_n.send_ack = 1'b1;
								res_n.ack_dest = item.rx_src;
							end
							res_n.deliver     = 1'b1;
							res_n.deliver_src = item.rx_src;
						end
					end else if (item.rx_dst == BROADCAST_ADDR) begin
						res_n.deliver     = 1'b1;
						res_n.deliver_src = item.rx_src;
					end
				end
				default: ;
			endcase

			// take the oldest pending frame once idle
			if (mode_n == MODE_IDLE && cnt_n != '0) begin
				cur_dest_n  = head[ENTRY_W-1:1];
				cur_ack_n   = head[0];
				rp_n        = rp_inc[PTR_W-1:0];
				cnt_n       = cnt_n - CNT_W'(1);
				attempt_n   = 4'd0;
				countdown_n = backoff_len(4'd0, item.random_value);
				mode_n      = MODE_BACKOFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			attempt_q   <= '0;
			countdown_q <= '0;
			cur_dest_q  <= '0;
			cur_ack_q   <= 1'b0;
			rp_q        <= '0;
			cnt_q       <= '0;
		end else begin
			mode_q      <= mode_n;
			attempt_q   <= attempt_n;
			countdown_q <= countdown_n;
			cur_dest_q  <= cur_dest_n;
			cur_ack_q   <= cur_ack_n;
			rp_q        <= rp_n;
			cnt_q       <= cnt_n;
		end
	end

	assign res       = res_n;
	assign res_valid = item_valid && (res_n.start_tx || (res_n.tx_outcome != OUTCOME_NONE)
	                   || (res_n.queue_status != QSTAT_NONE) || res_n.send_ack
	                   || res_n.deliver);

endmodule

`default_nettype wire

@@ src/csma_mac_tx_rx_controller_top.sv @@
// csma_mac_tx_rx_controller_top: stream ports, config port and output buffering
// depends on csma_pkg and csma_ctrl
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | command in tuser, frame and rx header in tdata
//  m_      | out | m_tvalid/m_tready  | tx request, outcome, queue status, ack, delivery
//  cfg_    | in  | cfg_valid/cfg_ready| register index and write data
//
// one item per cycle while s_tready is high; each item is settled in the cycle it is
// accepted, the queue memory read for the next head is registered that same edge
// results go to an output register backed by a skid register, so s_tready
// falls only while both hold results that the sink has not taken
// arst_n clears mac state and queue pointers, resets the registers; no clearing pass
`default_nettype none

module csma_mac_tx_rx_controller_top #(
	parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// dest_address, ack_request, payload_length, random_value, channel_clear,
	// rx_dst, rx_src, rx_ctrl, zero fill
	input  wire logic [csma_pkg::S_TDATA_W-1:0] s_tdata,
	// command
	input  wire logic [csma_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// start_tx, tx_dest, tx_outcome, queue_status, send_ack, ack_dest,
	// deliver, deliver_src, zero fill
	output logic      [csma_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [csma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csma_pkg::CFG_DAT_W-1:0] cfg_data
);
	import csma_pkg::*;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);

	logic    accept;
	item_t   item;
	cfg_wr_t cfg_wr;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign item      = item_t'(s_tdata[ITEM_W-1:0]);
	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

	csma_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.item_valid(accept),
		.item_cmd  (cmd_t'(s_tuser)),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_valid;
			end else begin
				out_valid_q  <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, out_q};

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench for csma_mac_tx_rx_controller_top: directed and random item streams with
// a cycle-free model of the mac that predicts every result, checked in order
// depends on csma_pkg and csma_mac_tx_rx_controller_top
`timescale 1ns / 1ps

module testbench;
	import csma_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	csma_mac_tx_rx_controller_top #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// mac model state and register copies
	mode_t mac_mode;
	logic [3:0] mac_attempt;
	logic [15:0] mac_count;
	logic [15:0] cur_dest;
	logic cur_ack;
	logic [ENTRY_W-1:0] frame_q [DEPTH];
	int rd_ptr;
	int n_pend;
	logic [15:0] my_addr;
	logic [15:0] ack_wait;
	logic [3:0] try_limit;

	result_t mac_events_due [$];
	int mismatches = 0;
	int results_predicted = 0;
	int burst_left = 0;
	bit item_mattered;
	int idle_cycles = 0;
	int ready_left = 0;
	int ready_style = 0;

	function automatic void begin_backoff(input logic [15:0] rnd);
		logic [31:0] mask;
		logic [31:0] ticks_w;
		mask = (32'd1 << (mac_attempt + BACKOFF_SHIFT)) - 32'd1;
		ticks_w = ({16'd0, rnd} & mask) + {16'd0, BACKOFF_BASE};
		mac_count = (ticks_w > 32'hFFFF) ? 16'hFFFF : ticks_w[15:0];
		mac_mode = MODE_BACKOFF;
	endfunction

	function automatic logic [1:0] next_attempt(input logic [15:0] rnd);
		logic [3:0] limit;
		limit = (try_limit == 4'd0) ? 4'd1 : try_limit;
		mac_attempt = mac_attempt + 4'd1;
		if (mac_attempt >= limit || mac_attempt == 4'd0) begin
			mac_mode = MODE_IDLE;
			return OUTCOME_GIVENUP;
		end
		begin_backoff(rnd);
		return OUTCOME_NONE;
	endfunction

	function automatic bit count_expired();
		if (mac_count <= 16'd1) begin
			mac_count = '0;
			return 1'b1;
		end
		mac_count = mac_count - 16'd1;
		return 1'b0;
	endfunction

	function automatic bit mac_predict(input cmd_t cmd, input item_t it, output result_t r);
		logic [1:0] rtype;
		r = '0;
		rtype = it.rx_ctrl[1:0];
		case (cmd)
			CMD_QUEUE: begin
				if (it.payload_length > MAX_PAYLOAD || n_pend >= DEPTH) begin
					r.queue_status = QSTAT_REJECT;
				end else begin
					frame_q[(rd_ptr + n_pend) % DEPTH] = {it.dest_address, it.ack_request};
					n_pend++;
					r.queue_status = QSTAT_ACCEPT;
				end
			end
			CMD_TICK: begin
				if (mac_mode == MODE_BACKOFF) begin
					if (count_expired()) begin
						r.start_tx = 1'b1;
						r.tx_dest = cur_dest;
						mac_mode = MODE_CCA;
					end
				end else if (mac_mode == MODE_ACK) begin
					if (count_expired())
						r.tx_outcome = next_attempt(it.random_value);
				end
			end
			CMD_CCA: begin
				if (mac_mode == MODE_CCA) begin
					if (!it.channel_clear) begin
						r.tx_outcome = next_attempt(it.random_value);
					end else if (cur_ack) begin
						mac_count = ack_wait;
						mac_mode = MODE_ACK;
					end else begin
						r.tx_outcome = OUTCOME_SENT;
						mac_mode = MODE_IDLE;
					end
				end
			end
			default: begin
				if (it.rx_dst == my_addr) begin
					if (rtype == TYPE_ACK) begin
						if (mac_mode == MODE_ACK && it.rx_src == cur_dest) begin
							r.tx_outcome = OUTCOME_SENT;
							mac_mode = MODE_IDLE;
						end
					end else begin
						if (rtype == TYPE_DATA && it.rx_ctrl[ACK_REQ_BIT]) begin
							r.send_ack = 1'b1;
							r.ack_dest = it.rx_src;
						end
						r.deliver = 1'b1;
						r.deliver_src = it.rx_src;
					end
				end else if (it.rx_dst == BROADCAST_ADDR) begin
					r.deliver = 1'b1;
					r.deliver_src = it.rx_src;
				end
			end
		endcase
		if (mac_mode == MODE_IDLE && n_pend > 0) begin
			{cur_dest, cur_ack} = frame_q[rd_ptr];
			rd_ptr = (rd_ptr + 1) % DEPTH;
			n_pend--;
			mac_attempt = '0;
			begin_backoff(it.random_value);
		end
		return r.start_tx || r.tx_outcome != OUTCOME_NONE || r.queue_status != QSTAT_NONE
			|| r.send_ack || r.deliver;
	endfunction

	function automatic logic [31:0] mac_snapshot();
		return {mac_mode, mac_attempt, mac_count, n_pend[7:0]};
	endfunction

	// backoff word: mostly short waits, upper bits always random
	function automatic logic [15:0] pick_rnd();
		logic [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			v[10:0] = 11'($urandom_range(0, 3));
		return v;
	endfunction

	function automatic item_t noise_item();
		logic [95:0] bits;
		item_t it;
		bits = {$urandom, $urandom, $urandom};
		it = bits[$bits(item_t)-1:0];
		it.random_value = pick_rnd();
		return it;
	endfunction

	function automatic logic [7:0] ctrl_of(input logic req, input logic [1:0] kind);
		return {req, 5'($urandom), kind};
	endfunction

	task automatic send_item(input cmd_t cmd, input item_t it);
		logic [S_TDATA_W-1:0] word;
		logic [31:0] prior;
		result_t r;
		bit has_result;
		word = '0;
		word[$bits(item_t)-1:0] = it;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		prior = mac_snapshot();
		has_result = mac_predict(cmd, it, r);
		if (has_result) begin
			mac_events_due.push_back(r);
			results_predicted++;
		end
		item_mattered = has_result || prior != mac_snapshot();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (mac_events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(input logic [15:0] addr, input logic [15:0] ack_ticks,
		input logic [3:0] limit);
		reg_idx_t order [3];
		logic [15:0] vals [3];
		order = '{REG_NODE_ADDR, REG_ACK_WAIT, REG_RETRY_LIM};
		vals = '{addr, ack_ticks, {12'd0, limit}};
		settle();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (order[i])
				REG_NODE_ADDR: my_addr = vals[i];
				REG_ACK_WAIT: ack_wait = vals[i];
				default: try_limit = vals[i][3:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_frame(input logic [15:0] dest, input logic want_ack,
		input logic [7:0] len, input logic [15:0] rnd);
		item_t it;
		it = noise_item();
		it.dest_address = dest;
		it.ack_request = want_ack;
		it.payload_length = len;
		it.random_value = rnd;
		send_item(CMD_QUEUE, it);
	endtask

	task automatic tick();
		send_item(CMD_TICK, noise_item());
	endtask

	task automatic cca(input logic clear, input logic [15:0] rnd);
		item_t it;
		it = noise_item();
		it.channel_clear = clear;
		it.random_value = rnd;
		send_item(CMD_CCA, it);
	endtask

	task automatic rx_header(input logic [15:0] dst, input logic [15:0] src,
		input logic [7:0] ctrl);
		item_t it;
		it = noise_item();
		it.rx_dst = dst;
		it.rx_src = src;
		it.rx_ctrl = ctrl;
		send_item(CMD_RX, it);
	endtask

	task automatic ticks_to_send();
		while (mac_mode == MODE_BACKOFF) tick();
	endtask

	task automatic ticks_to_timeout();
		while (mac_mode == MODE_ACK) tick();
	endtask

	task automatic drain_frames();
		while (mac_mode != MODE_IDLE || n_pend != 0) begin
			if (mac_mode == MODE_CCA)
				cca(1'($urandom_range(0, 3) != 0), pick_rnd());
			else if (mac_mode == MODE_ACK && $urandom_range(0, 3) == 0)
				rx_header(my_addr, cur_dest, ctrl_of(1'b0, TYPE_ACK));
			else
				tick();
		end
	endtask

	// reset values of the registers: address 0, an ack wait longer than a few ticks,
	// three attempts
	task automatic test_defaults();
		tick();
		cca(1'b1, pick_rnd());
		queue_frame(16'hA5C3, 1'b1, 8'd0, 16'd0);
		ticks_to_send();
		cca(1'b1, pick_rnd());
		rx_header(16'h0000, 16'hA5C3, ctrl_of(1'b0, TYPE_ACK));
		queue_frame(16'h5A3C, 1'b1, MAX_PAYLOAD, 16'd0);
		ticks_to_send();
		tick();
		cca(1'b1, pick_rnd());
		rx_header(16'h0000, 16'h1111, ctrl_of(1'b1, TYPE_ACK));
		repeat (10) tick();
		rx_header(16'h0000, 16'h5A3C, ctrl_of(1'b0, TYPE_ACK));
		queue_frame(16'h5A3C, 1'b0, 8'd7, 16'd0);
		while (mac_mode != MODE_IDLE) begin
			ticks_to_send();
			cca(1'b0, 16'd0);
		end
	endtask

	task automatic test_queue_limits();
		set_registers(16'h0001, 16'd4, 4'd1);
		queue_frame(16'h0F0F, 1'b0, MAX_PAYLOAD + 8'd1, pick_rnd());
		queue_frame(16'hF0F0, 1'b1, 8'hFF, pick_rnd());
		queue_frame(16'h3C3C, 1'b1, MAX_PAYLOAD, 16'd0);
		for (int i = 0; i < DEPTH; i++)
			queue_frame(16'($urandom), 1'($urandom), (i == 0) ? 8'd0 : 8'($urandom_range(1, 120)),
				pick_rnd());
		queue_frame(16'hC3C3, 1'b0, 8'd10, pick_rnd());
		drain_frames();
	endtask

	task automatic test_rx_paths();
		logic [15:0] nodes [2];
		logic [15:0] node;
		nodes = '{16'h1234, BROADCAST_ADDR};
		for (int i = 0; i < 2; i++) begin
			node = nodes[i];
			set_registers(node, 16'd10, 4'd3);
			rx_header(node, 16'($urandom), ctrl_of(1'b1, TYPE_DATA));
			rx_header(node, 16'($urandom), ctrl_of(1'b0, TYPE_DATA));
			rx_header(node, 16'($urandom), ctrl_of(1'b1, 2'd0));
			rx_header(node, 16'($urandom), ctrl_of(1'b1, 2'd3));
			rx_header(node, 16'($urandom), ctrl_of(1'b1, TYPE_ACK));
			rx_header(BROADCAST_ADDR, 16'($urandom), ctrl_of(1'b1, TYPE_DATA));
			rx_header(BROADCAST_ADDR, 16'($urandom), ctrl_of(1'b0, TYPE_ACK));
			rx_header(BROADCAST_ADDR, 16'($urandom), ctrl_of(1'b1, 2'd0));
			rx_header(node ^ 16'h0F0F, 16'($urandom), ctrl_of(1'b1, TYPE_DATA));
		end
	endtask

	// zero wait expires on the first tick; a longer wait runs out in full
	task automatic test_ack_timeouts();
		logic [15:0] waits [3];
		waits = '{16'd0, 16'd1, 16'd8};
		for (int i = 0; i < 3; i++) begin
			set_registers(16'h8001, waits[i], 4'd3);
			queue_frame(16'h7FFE, 1'b1, 8'd33, 16'd0);
			ticks_to_send();
			cca(1'b1, pick_rnd());
			rx_header(16'h8001, 16'h7FFF, ctrl_of(1'b0, TYPE_ACK));
			rx_header(16'h1234, 16'h7FFE, ctrl_of(1'b0, TYPE_ACK));
			ticks_to_timeout();
			ticks_to_send();
			cca(1'b1, pick_rnd());
			rx_header(16'h8001, 16'h7FFE, ctrl_of(1'b0, TYPE_ACK));
		end
	endtask

	// limit zero acts as one attempt; from attempt eleven a full random word
	// saturates the backoff, so no send request follows within a few ticks
	task automatic test_retries();
		logic [3:0] limits [2];
		limits = '{4'd1, 4'd0};
		for (int i = 0; i < 2; i++) begin
			set_registers(16'h2222, 16'd3, limits[i]);
			queue_frame(16'hC001, 1'b0, 8'd5, 16'd0);
			while (mac_mode != MODE_IDLE) begin
				ticks_to_send();
				cca(1'b0, 16'd0);
			end
		end
		set_registers(16'h2222, 16'd3, 4'd15);
		queue_frame(16'hC001, 1'b0, 8'd5, 16'd0);
		while (mac_attempt != 4'd11) begin
			ticks_to_send();
			cca(1'b0, (mac_attempt == 4'd10) ? 16'hFFFF : 16'd0);
		end
		repeat (24) tick();
	endtask

	task automatic random_item();
		item_t it;
		cmd_t cmd;
		int sel;
		it = noise_item();
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			cmd = cmd_t'($urandom_range(0, 3));
		end else if (sel < 20 || (sel >= 32 && mac_mode == MODE_IDLE)) begin
			cmd = CMD_QUEUE;
			if ($urandom_range(0, 5) != 0)
				it.payload_length = 8'($urandom_range(0, 120));
		end else if (sel < 32) begin
			cmd = CMD_RX;
			case ($urandom_range(0, 4))
				0, 1: it.rx_dst = my_addr;
				2: it.rx_dst = BROADCAST_ADDR;
				default: ;
			endcase
			if ($urandom_range(0, 2) == 0)
				it.rx_src = cur_dest;
		end else if (mac_mode == MODE_CCA) begin
			cmd = CMD_CCA;
			it.channel_clear = ($urandom_range(0, 3) != 0);
		end else if (mac_mode == MODE_ACK && $urandom_range(0, 1) == 1) begin
			cmd = CMD_RX;
			it.rx_dst = my_addr;
			it.rx_src = cur_dest;
			it.rx_ctrl[1:0] = TYPE_ACK;
		end else begin
			cmd = CMD_TICK;
		end
		send_item(cmd, it);
	endtask

	task automatic test_random_traffic();
		int counted;
		int made;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_registers(16'($urandom), 16'($urandom_range(0, 24)),
					4'($urandom_range(1, 4)));
				1: set_registers(BROADCAST_ADDR, 16'd0, 4'd0);
				2: set_registers(16'd0, 16'($urandom_range(2, 30)), 4'd4);
				default: set_registers(16'($urandom), 16'd1, 4'($urandom_range(1, 3)));
			endcase
			counted = 0;
			made = results_predicted;
			while (counted < 15 || results_predicted - made < 8) begin
				random_item();
				if (item_mattered)
					counted++;
			end
			drain_frames();
		end
	endtask

	task automatic report(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, what);
			$display("  expected start=%0b/%h outcome=%0d queue=%0d ack=%0b/%h deliver=%0b/%h",
				want.start_tx, want.tx_dest, want.tx_outcome, want.queue_status,
				want.send_ack, want.ack_dest, want.deliver, want.deliver_src);
			$display("  actual   start=%0b/%h outcome=%0d queue=%0d ack=%0b/%h deliver=%0b/%h",
				got.start_tx, got.tx_dest, got.tx_outcome, got.queue_status,
				got.send_ack, got.ack_dest, got.deliver, got.deliver_src);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (mac_events_due.size() == 0) begin
				report("result with nothing expected", '0, got);
			end else begin
				want = mac_events_due.pop_front();
				if (got.start_tx !== want.start_tx || got.tx_dest !== want.tx_dest
					|| got.tx_outcome !== want.tx_outcome
					|| got.queue_status !== want.queue_status
					|| got.send_ack !== want.send_ack || got.ack_dest !== want.ack_dest
					|| got.deliver !== want.deliver || got.deliver_src !== want.deliver_src)
					report("result mismatch", want, got);
			end
		end
	end

	// sink back-pressure in stretches of differing character
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_style = $urandom_range(0, 3);
			ready_left = $urandom_range(16, 256);
		end else begin
			ready_left--;
		end
		case (ready_style)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (ready_left % 16) < 11;
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		mac_mode = MODE_IDLE;
		mac_attempt = '0;
		mac_count = '0;
		cur_dest = '0;
		cur_ack = 1'b0;
		rd_ptr = 0;
		n_pend = 0;
		my_addr = NODE_ADDR_RST;
		ack_wait = ACK_WAIT_RST;
		try_limit = RETRY_LIM_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_queue_limits();
		test_rx_paths();
		test_ack_timeouts();
		test_random_traffic();
		test_retries();
		settle();
		mismatches += mac_events_due.size();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
src/csma_pkg.sv
src/csma_fifo_mem.sv
src/csma_ctrl.sv
src/csma_mac_tx_rx_controller_top.sv
verif/testbench.sv
